// ===== sv/spc_pkg.sv =====
// Shared constants, status codes and types of the polygon contact block.
package spc_pkg;

    localparam int MAX_VERTICES_DEF = 16;
    localparam int FRAC_BITS_DEF    = 16;
    localparam int MIN_VERTICES     = 3;
    localparam int COORD_W          = 32;
    localparam int VEC_W            = 34;
    localparam int NORM_W           = 18;
    localparam int DEPTH_W          = 32;
    localparam int STATUS_W         = 2;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_DEGEN = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_OVFL  = 2'd2;

    typedef struct packed {
        logic                    start;
        logic signed [VEC_W-1:0] vx;
        logic signed [VEC_W-1:0] vy;
    } t_axis_req;

endpackage

// ===== sv/spc_axis_unit.sv =====
// Iterative unit that turns an edge normal vector into a fixed point unit axis.
module spc_axis_unit #(
    parameter int FRAC_BITS = spc_pkg::FRAC_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  spc_pkg::t_axis_req         i_req,
    output logic                       o_done,
    output logic signed [FRAC_BITS+1:0] o_nx,
    output logic signed [FRAC_BITS+1:0] o_ny
);
    import spc_pkg::*;

    localparam int NW       = FRAC_BITS + 2;
    localparam int MW       = 31;
    localparam int SQ_STEPS = 32;
    localparam logic [NW-1:0] UNIT = NW'(1) << FRAC_BITS;

    typedef enum logic [2:0] {
        S_IDLE, S_MUL, S_SUM, S_SQRT, S_DIVI, S_DIV, S_FIN
    } t_state;

    t_state              r_state;
    logic [5:0]          r_cnt;
    logic [MW-1:0]       r_ax, r_ay;
    logic                r_sx, r_sy;
    logic [2*MW-1:0]     r_sqx, r_sqy;
    logic [63:0]         r_v;
    logic [35:0]         r_rem;
    logic [31:0]         r_root;
    logic [63:0]         r_numx, r_numy, r_d;
    logic [NW-1:0]       r_qx, r_qy;

    logic [VEC_W-1:0]    w_mx, w_my;
    logic [35:0]         w_rem_sh, w_trial;
    logic [31:0]         w_len;
    logic [NW-1:0]       w_cx, w_cy;

    // Magnitudes, halved together until both fit in 31 bits.
    always_comb begin
        w_mx = i_req.vx[VEC_W-1] ? VEC_W'(VEC_W'(0) - i_req.vx) : VEC_W'(i_req.vx);
        w_my = i_req.vy[VEC_W-1] ? VEC_W'(VEC_W'(0) - i_req.vy) : VEC_W'(i_req.vy);
        for (int k = 0; k < VEC_W - MW; k++) begin
            if ((|w_mx[VEC_W-1:MW]) || (|w_my[VEC_W-1:MW])) begin
                w_mx = w_mx >> 1;
                w_my = w_my >> 1;
            end
        end
    end

    assign w_rem_sh = {r_rem[33:0], r_v[63:62]};
    assign w_trial  = {2'b00, r_root, 2'b01};
    assign w_len    = (r_root == '0) ? 32'd1 : r_root;
    assign w_cx     = (r_qx > UNIT) ? UNIT : r_qx;
    assign w_cy     = (r_qy > UNIT) ? UNIT : r_qy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_done  <= 1'b0;
        end else begin
            o_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_req.start) begin
                        r_ax <= w_mx[MW-1:0];
                        r_ay <= w_my[MW-1:0];
                        r_sx <= i_req.vx[VEC_W-1];
                        r_sy <= i_req.vy[VEC_W-1];
                        if (w_mx == '0 && w_my == '0) begin
                            r_qx    <= UNIT;
                            r_qy    <= '0;
                            r_sx    <= 1'b0;
                            r_sy    <= 1'b0;
                            r_state <= S_FIN;
                        end else begin
                            r_state <= S_MUL;
                        end
                    end
                end
                S_MUL: begin
                    r_sqx   <= r_ax * r_ax;
                    r_sqy   <= r_ay * r_ay;
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_v     <= 64'(r_sqx) + 64'(r_sqy);
                    r_rem   <= '0;
                    r_root  <= '0;
                    r_cnt   <= '0;
                    r_state <= S_SQRT;
                end
                S_SQRT: begin
                    // One root bit per cycle, restoring.
                    if (w_rem_sh >= w_trial) begin
                        r_rem  <= w_rem_sh - w_trial;
                        r_root <= {r_root[30:0], 1'b1};
                    end else begin
                        r_rem  <= w_rem_sh;
                        r_root <= {r_root[30:0], 1'b0};
                    end
                    r_v <= r_v << 2;
                    if (r_cnt == 6'(SQ_STEPS - 1)) begin
                        r_state <= S_DIVI;
                    end
                    r_cnt <= r_cnt + 6'd1;
                end
                S_DIVI: begin
                    r_numx  <= (64'(r_ax) << FRAC_BITS) + 64'(w_len >> 1);
                    r_numy  <= (64'(r_ay) << FRAC_BITS) + 64'(w_len >> 1);
                    r_d     <= 64'(w_len) << (NW - 1);
                    r_qx    <= '0;
                    r_qy    <= '0;
                    r_cnt   <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    // The quotient stays below 2^NW, so NW steps suffice.
                    if (r_numx >= r_d) begin
                        r_numx <= r_numx - r_d;
                        r_qx   <= {r_qx[NW-2:0], 1'b1};
                    end else begin
                        r_qx   <= {r_qx[NW-2:0], 1'b0};
                    end
                    if (r_numy >= r_d) begin
                        r_numy <= r_numy - r_d;
                        r_qy   <= {r_qy[NW-2:0], 1'b1};
                    end else begin
                        r_qy   <= {r_qy[NW-2:0], 1'b0};
                    end
                    r_d <= r_d >> 1;
                    if (r_cnt == 6'(NW - 1)) begin
                        r_state <= S_FIN;
                    end
                    r_cnt <= r_cnt + 6'd1;
                end
                S_FIN: begin
                    o_nx    <= r_sx ? NW'(NW'(0) - w_cx) : w_cx;
                    o_ny    <= r_sy ? NW'(NW'(0) - w_cy) : w_cy;
                    o_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== sv/sat_polygon_polygon_contact.sv =====
// Top level of the convex polygon pair contact test by separating axes.
//
// Vertices of polygon A and polygon B arrive one request at a time, tagged by
// which_polygon, and are written into two on-chip vertex memories of
// MAX_VERTICES entries each; vertices load one per cycle while the block is idle. The request
// with pair_done set stores its vertex and starts the test, during which no
// request is taken. A polygon with fewer than three vertices gives status 1, and
// a vertex beyond MAX_VERTICES is dropped and gives status 2. Otherwise each
// edge of A and then of B yields a unit normal from the iterative axis unit (a
// 32 step square root plus a FRAC_BITS+2 step divider), then a projection sweep
// that reads both memories at the same index, one index per cycle, and a
// pipeline drain. The test stops at the first separating axis, and one more
// sweep over the chosen axis decides its sign. The result sits in an output
// register, so vertices of the next pair load while it waits to be taken.
// Normals are Q2.FRAC_BITS pointing from B to A, depth is Q16.16 truncated and
// saturating, and both are zero without a hit.
module sat_polygon_polygon_contact #(
    parameter int MAX_VERTICES = spc_pkg::MAX_VERTICES_DEF,
    parameter int FRAC_BITS    = spc_pkg::FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_which_polygon,
    input  logic signed [spc_pkg::COORD_W-1:0]  i_vertex_x,
    input  logic signed [spc_pkg::COORD_W-1:0]  i_vertex_y,
    input  logic                                i_pair_done,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic                                o_hit,
    output logic signed [spc_pkg::NORM_W-1:0]   o_normal_x,
    output logic signed [spc_pkg::NORM_W-1:0]   o_normal_y,
    output logic [spc_pkg::DEPTH_W-1:0]         o_depth,
    output logic [spc_pkg::STATUS_W-1:0]        o_status
);
    import spc_pkg::*;

    localparam int AW  = $clog2(MAX_VERTICES);
    localparam int CW  = $clog2(MAX_VERTICES + 1);
    localparam int NW  = FRAC_BITS + 2;
    localparam int PRW = COORD_W + NW;
    localparam int PW  = PRW + 1;
    localparam int OW  = PW + 1;
    localparam int SW  = PW + CW;
    localparam int XW  = SW + CW + 1;
    localparam int EW  = 2 * COORD_W;

    typedef enum logic [3:0] {
        ST_IDLE, ST_E0, ST_E1, ST_E2, ST_AXW, ST_PINIT, ST_PROJ, ST_DRAIN,
        ST_EVAL, ST_MMUL, ST_MCMP, ST_FIN
    } t_state;

    // Vertex memories: x in the upper half of an entry, y in the lower half.
    logic [EW-1:0] r_mem_a [MAX_VERTICES];
    logic [EW-1:0] r_mem_b [MAX_VERTICES];
    logic [EW-1:0] r_rd_a, r_rd_b;

    t_state               r_state;
    logic [CW-1:0]        r_count_a, r_count_b;
    logic                 r_ovf;
    logic                 r_phase;
    logic                 r_mean;
    logic [CW-1:0]        r_edge;
    logic [CW-1:0]        r_pi;
    logic [EW-1:0]        r_p0;
    logic signed [NW-1:0] r_cur_nx, r_cur_ny;
    logic signed [NW-1:0] r_best_nx, r_best_ny;
    logic signed [OW-1:0] r_best;
    logic                 r_best_first;
    logic signed [XW-1:0] r_lhs, r_rhs;

    logic                        r_res_hit;
    logic signed [NORM_W-1:0]    r_res_nx, r_res_ny;
    logic [DEPTH_W-1:0]          r_res_depth;
    logic [STATUS_W-1:0]         r_res_status;

    // Projection pipeline.
    logic                  r_s1_va, r_s1_vb, r_s2_va, r_s2_vb, r_s3_va, r_s3_vb;
    logic signed [PRW-1:0] r_pax, r_pay, r_pbx, r_pby;
    logic signed [PW-1:0]  r_da, r_db;
    logic signed [PW-1:0]  r_mina, r_maxa, r_minb, r_maxb;
    logic signed [SW-1:0]  r_suma, r_sumb;
    logic                  r_first_a, r_first_b;

    logic                    w_accept;
    logic                    w_we_a, w_we_b;
    logic [EW-1:0]           w_entry;
    logic [CW-1:0]           w_ca_n, w_cb_n;
    logic                    w_ovf_n;
    logic [AW-1:0]           w_raddr;
    logic [CW-1:0]           w_n_phase, w_edge_inc, w_edge_nxt, w_pmax;
    logic [EW-1:0]           w_sel_rd;
    logic signed [COORD_W:0] w_ex, w_ey;
    t_axis_req               w_req;
    logic                    w_ax_done;
    logic signed [NW-1:0]    w_ax_nx, w_ax_ny;
    logic signed [COORD_W-1:0] w_ax_x, w_ax_y, w_bx_x, w_bx_y;
    logic                    w_pipe_busy;
    logic signed [PW-1:0]    w_lo_max, w_hi_min;
    logic signed [OW-1:0]    w_ov;
    logic                    w_take;
    logic signed [NW-1:0]    w_nb_nx, w_nb_ny;
    logic                    w_below;
    logic signed [NW-1:0]    w_fx, w_fy;
    logic [OW-1:0]           w_bsh;
    logic [DEPTH_W-1:0]      w_depth;
    logic                    w_out_free;

    assign o_in_ready = (r_state == ST_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_entry    = {i_vertex_x, i_vertex_y};

    // A vertex for a full polygon is dropped and remembered as an overflow.
    assign w_we_a  = w_accept && !i_which_polygon && (r_count_a != CW'(MAX_VERTICES));
    assign w_we_b  = w_accept &&  i_which_polygon && (r_count_b != CW'(MAX_VERTICES));
    assign w_ca_n  = w_we_a ? CW'(r_count_a + CW'(1)) : r_count_a;
    assign w_cb_n  = w_we_b ? CW'(r_count_b + CW'(1)) : r_count_b;
    assign w_ovf_n = r_ovf || (w_accept && !w_we_a && !w_we_b);

    assign w_n_phase  = r_phase ? r_count_b : r_count_a;
    assign w_edge_inc = CW'(r_edge + CW'(1));
    assign w_edge_nxt = (w_edge_inc == w_n_phase) ? '0 : w_edge_inc;
    assign w_pmax     = (r_count_a > r_count_b) ? r_count_a : r_count_b;

    always_comb begin
        case (r_state)
            ST_E0:   w_raddr = r_edge[AW-1:0];
            ST_E1:   w_raddr = w_edge_nxt[AW-1:0];
            default: w_raddr = r_pi[AW-1:0];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we_a) begin
            r_mem_a[r_count_a[AW-1:0]] <= w_entry;
        end
        if (w_we_b) begin
            r_mem_b[r_count_b[AW-1:0]] <= w_entry;
        end
        r_rd_a <= r_mem_a[w_raddr];
        r_rd_b <= r_mem_b[w_raddr];
    end

    // Edge vector p1 - p0; its normal (-ey, ex) goes to the axis unit.
    assign w_sel_rd = r_phase ? r_rd_b : r_rd_a;
    assign w_ex = (COORD_W+1)'(signed'(w_sel_rd[EW-1:COORD_W]))
                - (COORD_W+1)'(signed'(r_p0[EW-1:COORD_W]));
    assign w_ey = (COORD_W+1)'(signed'(w_sel_rd[COORD_W-1:0]))
                - (COORD_W+1)'(signed'(r_p0[COORD_W-1:0]));

    always_comb begin
        w_req.start = (r_state == ST_E2);
        w_req.vx    = VEC_W'(VEC_W'(0) - VEC_W'(w_ey));
        w_req.vy    = VEC_W'(w_ex);
    end

    spc_axis_unit #(
        .FRAC_BITS (FRAC_BITS)
    ) u_axis (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_done  (w_ax_done),
        .o_nx    (w_ax_nx),
        .o_ny    (w_ax_ny)
    );

    // Projection pipeline: memory read, products, dot product, min/max/sum.
    assign w_ax_x = r_rd_a[EW-1:COORD_W];
    assign w_ax_y = r_rd_a[COORD_W-1:0];
    assign w_bx_x = r_rd_b[EW-1:COORD_W];
    assign w_bx_y = r_rd_b[COORD_W-1:0];
    assign w_pipe_busy = r_s1_va || r_s1_vb || r_s2_va || r_s2_vb || r_s3_va || r_s3_vb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_va <= 1'b0;
            r_s1_vb <= 1'b0;
            r_s2_va <= 1'b0;
            r_s2_vb <= 1'b0;
            r_s3_va <= 1'b0;
            r_s3_vb <= 1'b0;
        end else begin
            r_s1_va <= (r_state == ST_PROJ) && (r_pi < r_count_a);
            r_s1_vb <= (r_state == ST_PROJ) && (r_pi < r_count_b);
            r_s2_va <= r_s1_va;
            r_s2_vb <= r_s1_vb;
            r_s3_va <= r_s2_va;
            r_s3_vb <= r_s2_vb;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pax <= w_ax_x * r_cur_nx;
        r_pay <= w_ax_y * r_cur_ny;
        r_pbx <= w_bx_x * r_cur_nx;
        r_pby <= w_bx_y * r_cur_ny;
        r_da  <= PW'(r_pax) + PW'(r_pay);
        r_db  <= PW'(r_pbx) + PW'(r_pby);
        if (r_state == ST_PINIT) begin
            r_first_a <= 1'b1;
            r_first_b <= 1'b1;
            r_suma    <= '0;
            r_sumb    <= '0;
        end else begin
            if (r_s3_va) begin
                r_first_a <= 1'b0;
                r_suma    <= r_suma + SW'(r_da);
                if (r_first_a || r_da < r_mina) r_mina <= r_da;
                if (r_first_a || r_da > r_maxa) r_maxa <= r_da;
            end
            if (r_s3_vb) begin
                r_first_b <= 1'b0;
                r_sumb    <= r_sumb + SW'(r_db);
                if (r_first_b || r_db < r_minb) r_minb <= r_db;
                if (r_first_b || r_db > r_maxb) r_maxb <= r_db;
            end
        end
    end

    // Overlap on the current axis, and whether it becomes the new best.
    assign w_lo_max = (r_maxa < r_maxb) ? r_maxa : r_maxb;
    assign w_hi_min = (r_mina > r_minb) ? r_mina : r_minb;
    assign w_ov     = OW'(w_lo_max) - OW'(w_hi_min);
    assign w_take   = r_best_first || (w_ov < r_best);
    assign w_nb_nx  = w_take ? r_cur_nx : r_best_nx;
    assign w_nb_ny  = w_take ? r_cur_ny : r_best_ny;

    // The axis flips when A's mean projection lies strictly below B's.
    assign w_below = r_lhs < r_rhs;
    assign w_fx    = w_below ? NW'(NW'(0) - r_best_nx) : r_best_nx;
    assign w_fy    = w_below ? NW'(NW'(0) - r_best_ny) : r_best_ny;
    assign w_bsh   = r_best >> FRAC_BITS;
    assign w_depth = (|w_bsh[OW-1:DEPTH_W]) ? '1 : w_bsh[DEPTH_W-1:0];

    assign w_out_free = !o_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count_a   <= '0;
            r_count_b   <= '0;
            r_ovf       <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            // A new result replaces a taken one in the same cycle.
            if (r_state == ST_FIN && w_out_free) begin
                o_out_valid <= 1'b1;
            end else if (o_out_valid && i_out_ready) begin
                o_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_count_a <= w_ca_n;
                        r_count_b <= w_cb_n;
                        r_ovf     <= w_ovf_n;
                        if (i_pair_done) begin
                            r_res_hit    <= 1'b0;
                            r_res_nx     <= '0;
                            r_res_ny     <= '0;
                            r_res_depth  <= '0;
                            r_phase      <= 1'b0;
                            r_edge       <= '0;
                            r_mean       <= 1'b0;
                            r_best_first <= 1'b1;
                            if (w_ovf_n) begin
                                r_res_status <= STATUS_OVFL;
                                r_state      <= ST_FIN;
                            end else if (w_ca_n < CW'(MIN_VERTICES) ||
                                         w_cb_n < CW'(MIN_VERTICES)) begin
                                r_res_status <= STATUS_DEGEN;
                                r_state      <= ST_FIN;
                            end else begin
                                r_res_status <= STATUS_OK;
                                r_state      <= ST_E0;
                            end
                        end
                    end
                end
                ST_E0: r_state <= ST_E1;
                ST_E1: begin
                    r_p0    <= w_sel_rd;
                    r_state <= ST_E2;
                end
                ST_E2: r_state <= ST_AXW;
                ST_AXW: begin
                    if (w_ax_done) begin
                        r_cur_nx <= w_ax_nx;
                        r_cur_ny <= w_ax_ny;
                        r_state  <= ST_PINIT;
                    end
                end
                ST_PINIT: begin
                    r_pi    <= '0;
                    r_state <= ST_PROJ;
                end
                ST_PROJ: begin
                    if (r_pi == CW'(w_pmax - CW'(1))) begin
                        r_state <= ST_DRAIN;
                    end
                    r_pi <= CW'(r_pi + CW'(1));
                end
                ST_DRAIN: begin
                    if (!w_pipe_busy) begin
                        r_state <= r_mean ? ST_MMUL : ST_EVAL;
                    end
                end
                ST_EVAL: begin
                    if (w_ov[OW-1] || w_ov == '0) begin
                        // Separating axis found: no contact.
                        r_state <= ST_FIN;
                    end else begin
                        if (w_take) begin
                            r_best    <= w_ov;
                            r_best_nx <= r_cur_nx;
                            r_best_ny <= r_cur_ny;
                        end
                        r_best_first <= 1'b0;
                        if (w_edge_inc < w_n_phase) begin
                            r_edge  <= w_edge_inc;
                            r_state <= ST_E0;
                        end else if (!r_phase) begin
                            r_phase <= 1'b1;
                            r_edge  <= '0;
                            r_state <= ST_E0;
                        end else begin
                            // All axes overlap: sweep once more on the best axis.
                            r_mean   <= 1'b1;
                            r_cur_nx <= w_nb_nx;
                            r_cur_ny <= w_nb_ny;
                            r_state  <= ST_PINIT;
                        end
                    end
                end
                ST_MMUL: begin
                    r_lhs   <= r_suma * signed'({1'b0, r_count_b});
                    r_rhs   <= r_sumb * signed'({1'b0, r_count_a});
                    r_state <= ST_MCMP;
                end
                ST_MCMP: begin
                    r_res_hit   <= 1'b1;
                    r_res_nx    <= NORM_W'(w_fx);
                    r_res_ny    <= NORM_W'(w_fy);
                    r_res_depth <= w_depth;
                    r_state     <= ST_FIN;
                end
                ST_FIN: begin
                    if (w_out_free) begin
                        o_hit       <= r_res_hit;
                        o_normal_x  <= r_res_nx;
                        o_normal_y  <= r_res_ny;
                        o_depth     <= r_res_depth;
                        o_status    <= r_res_status;
                        r_count_a   <= '0;
                        r_count_b   <= '0;
                        r_ovf       <= 1'b0;
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_hit_status_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_hit |-> o_status == STATUS_OK)
        else $error("Contact reported with a non-ok status.");

    a_nohit_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_hit |-> o_depth == '0 && o_normal_x == '0 && o_normal_y == '0)
        else $error("Result without contact carries a nonzero normal or depth.");

    a_test_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_pair_done |=> !o_in_ready)
        else $error("Request taken while the contact test was starting.");
`endif

endmodule
